[rtl/nt_hash_md5_salted_digest_macros.svh]
// Assertion macros for the salted NT-hash digest block.
`ifndef NT_HASH_MD5_SALTED_DIGEST_MACROS_SVH
`define NT_HASH_MD5_SALTED_DIGEST_MACROS_SVH
`ifndef SYNTH
`define NTS_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define NTS_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define NTS_ASSERT_IMPL(label, clk, rst, a, c)
`define NTS_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

[rtl/ntsd_pkg.sv]
// Shared types, constants and round tables for the salted NT-hash digest.
package ntsd_pkg;

  localparam int MaxKeyChars = 27;
  localparam int SaltBytes   = 48;
  localparam int SaltRegs    = 6;
  localparam int TotalBytes  = 16 + SaltBytes;
  localparam int Md5Blocks   = (TotalBytes + 9 <= 64) ? 1 : 2;
  localparam int Md4Rounds   = 48;
  localparam int Md5Rounds   = 64 * Md5Blocks;
  localparam int CfgIdxW     = 3;

  localparam logic [31:0] IvA = 32'h67452301;
  localparam logic [31:0] IvB = 32'hefcdab89;
  localparam logic [31:0] IvC = 32'h98badcfe;
  localparam logic [31:0] IvD = 32'h10325476;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } hstate_t;

  typedef logic [15:0][31:0] block_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] s);
    rotl = (v << s) | (v >> (6'd32 - {1'b0, s}));
  endfunction

  function automatic logic [3:0] md4_idx(input logic [5:0] j);
    logic [1:0] r;
    logic [3:0] p;
    r = j[5:4];
    p = j[3:0];
    case (r)
      2'd0: md4_idx = p;
      2'd1: md4_idx = {p[1:0], p[3:2]};
      default: md4_idx = {p[0], p[1], p[2], p[3]};
    endcase
  endfunction

  function automatic logic [4:0] md4_s(input logic [5:0] j);
    logic [3:0] k;
    k = {j[5:4], j[1:0]};
    case (k)
      4'd0: md4_s = 5'd3;   4'd1: md4_s = 5'd7;   4'd2: md4_s = 5'd11;  4'd3: md4_s = 5'd19;
      4'd4: md4_s = 5'd3;   4'd5: md4_s = 5'd5;   4'd6: md4_s = 5'd9;   4'd7: md4_s = 5'd13;
      4'd8: md4_s = 5'd3;   4'd9: md4_s = 5'd9;   4'd10: md4_s = 5'd11; 4'd11: md4_s = 5'd15;
      default: md4_s = 5'd0;
    endcase
  endfunction

  function automatic logic [31:0] md4_k(input logic [5:0] j);
    case (j[5:4])
      2'd0: md4_k = 32'h0;
      2'd1: md4_k = 32'h5a827999;
      default: md4_k = 32'h6ed9eba1;
    endcase
  endfunction

  function automatic logic [31:0] md5_k(input logic [5:0] j);
    case (j)
      6'd0: md5_k = 32'hd76aa478;  6'd1: md5_k = 32'he8c7b756;
      6'd2: md5_k = 32'h242070db;  6'd3: md5_k = 32'hc1bdceee;
      6'd4: md5_k = 32'hf57c0faf;  6'd5: md5_k = 32'h4787c62a;
      6'd6: md5_k = 32'ha8304613;  6'd7: md5_k = 32'hfd469501;
      6'd8: md5_k = 32'h698098d8;  6'd9: md5_k = 32'h8b44f7af;
      6'd10: md5_k = 32'hffff5bb1; 6'd11: md5_k = 32'h895cd7be;
      6'd12: md5_k = 32'h6b901122; 6'd13: md5_k = 32'hfd987193;
      6'd14: md5_k = 32'ha679438e; 6'd15: md5_k = 32'h49b40821;
      6'd16: md5_k = 32'hf61e2562; 6'd17: md5_k = 32'hc040b340;
      6'd18: md5_k = 32'h265e5a51; 6'd19: md5_k = 32'he9b6c7aa;
      6'd20: md5_k = 32'hd62f105d; 6'd21: md5_k = 32'h02441453;
      6'd22: md5_k = 32'hd8a1e681; 6'd23: md5_k = 32'he7d3fbc8;
      6'd24: md5_k = 32'h21e1cde6; 6'd25: md5_k = 32'hc33707d6;
      6'd26: md5_k = 32'hf4d50d87; 6'd27: md5_k = 32'h455a14ed;
      6'd28: md5_k = 32'ha9e3e905; 6'd29: md5_k = 32'hfcefa3f8;
      6'd30: md5_k = 32'h676f02d9; 6'd31: md5_k = 32'h8d2a4c8a;
      6'd32: md5_k = 32'hfffa3942; 6'd33: md5_k = 32'h8771f681;
      6'd34: md5_k = 32'h6d9d6122; 6'd35: md5_k = 32'hfde5380c;
      6'd36: md5_k = 32'ha4beea44; 6'd37: md5_k = 32'h4bdecfa9;
      6'd38: md5_k = 32'hf6bb4b60; 6'd39: md5_k = 32'hbebfbc70;
      6'd40: md5_k = 32'h289b7ec6; 6'd41: md5_k = 32'heaa127fa;
      6'd42: md5_k = 32'hd4ef3085; 6'd43: md5_k = 32'h04881d05;
      6'd44: md5_k = 32'hd9d4d039; 6'd45: md5_k = 32'he6db99e5;
      6'd46: md5_k = 32'h1fa27cf8; 6'd47: md5_k = 32'hc4ac5665;
      6'd48: md5_k = 32'hf4292244; 6'd49: md5_k = 32'h432aff97;
      6'd50: md5_k = 32'hab9423a7; 6'd51: md5_k = 32'hfc93a039;
      6'd52: md5_k = 32'h655b59c3; 6'd53: md5_k = 32'h8f0ccc92;
      6'd54: md5_k = 32'hffeff47d; 6'd55: md5_k = 32'h85845dd1;
      6'd56: md5_k = 32'h6fa87e4f; 6'd57: md5_k = 32'hfe2ce6e0;
      6'd58: md5_k = 32'ha3014314; 6'd59: md5_k = 32'h4e0811a1;
      6'd60: md5_k = 32'hf7537e82; 6'd61: md5_k = 32'hbd3af235;
      6'd62: md5_k = 32'h2ad7d2bb; default: md5_k = 32'heb86d391;
    endcase
  endfunction

  function automatic logic [4:0] md5_s(input logic [5:0] j);
    case ({j[5:4], j[1:0]})
      4'd0: md5_s = 5'd7;   4'd1: md5_s = 5'd12;  4'd2: md5_s = 5'd17;  4'd3: md5_s = 5'd22;
      4'd4: md5_s = 5'd5;   4'd5: md5_s = 5'd9;   4'd6: md5_s = 5'd14;  4'd7: md5_s = 5'd20;
      4'd8: md5_s = 5'd4;   4'd9: md5_s = 5'd11;  4'd10: md5_s = 5'd16; 4'd11: md5_s = 5'd23;
      4'd12: md5_s = 5'd6;  4'd13: md5_s = 5'd10; 4'd14: md5_s = 5'd15; default: md5_s = 5'd21;
    endcase
  endfunction

  function automatic logic [3:0] md5_g(input logic [5:0] j);
    logic [3:0] p;
    p = j[3:0];
    case (j[5:4])
      2'd0: md5_g = p;
      2'd1: md5_g = 4'(5 * p + 1);
      2'd2: md5_g = 4'(3 * p + 5);
      default: md5_g = 4'(7 * p);
    endcase
  endfunction

endpackage

[rtl/ntsd_round_cell.sv]
// One MD4 or MD5 round step holding the running state and the message block of one item.
module ntsd_round_cell #(
  parameter bit IsMd5 = 1'b0,
  parameter logic [5:0] Step = 6'd0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  ntsd_pkg::hstate_t in_state,
  input  ntsd_pkg::hstate_t in_iv,
  input  ntsd_pkg::block_t  in_blk,
  output logic              out_valid,
  output ntsd_pkg::hstate_t out_state,
  output ntsd_pkg::hstate_t out_iv,
  output ntsd_pkg::block_t  out_blk
);
  logic [31:0] f;
  logic [31:0] t;
  logic [31:0] nb;
  logic [31:0] a, b, c, d;

  always_comb begin
    a = in_state.a; b = in_state.b; c = in_state.c; d = in_state.d;
    if (IsMd5) begin
      case (Step[5:4])
        2'd0: f = (b & c) | (~b & d);
        2'd1: f = (d & b) | (~d & c);
        2'd2: f = b ^ c ^ d;
        default: f = c ^ (b | ~d);
      endcase
      t  = a + f + ntsd_pkg::md5_k(Step) + in_blk[ntsd_pkg::md5_g(Step)];
      nb = b + ntsd_pkg::rotl(t, ntsd_pkg::md5_s(Step));
    end else begin
      case (Step[5:4])
        2'd0: f = (b & c) | (~b & d);
        2'd1: f = (b & c) | (b & d) | (c & d);
        default: f = b ^ c ^ d;
      endcase
      t  = a + f + in_blk[ntsd_pkg::md4_idx(Step)] + ntsd_pkg::md4_k(Step);
      nb = ntsd_pkg::rotl(t, ntsd_pkg::md4_s(Step));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_state <= '{a: d, b: nb, c: b, d: c};
    out_iv    <= in_iv;
    out_blk   <= in_blk;
  end
endmodule

[rtl/ntsd_chain.sv]
// Row of round cells for one hash block, ending in the feed-forward add.
module ntsd_chain #(
  parameter bit IsMd5 = 1'b0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  ntsd_pkg::hstate_t in_iv,
  input  ntsd_pkg::block_t  in_blk,
  output logic              out_valid,
  output ntsd_pkg::hstate_t out_hash
);
  localparam int N = IsMd5 ? 64 : ntsd_pkg::Md4Rounds;

  logic              v  [N+1];
  ntsd_pkg::hstate_t st [N+1];
  ntsd_pkg::hstate_t iv [N+1];
  ntsd_pkg::block_t  bk [N+1];

  assign v[0]  = in_valid;
  assign st[0] = in_iv;
  assign iv[0] = in_iv;
  assign bk[0] = in_blk;

  for (genvar j = 0; j < N; j++) begin : g_cell
    ntsd_round_cell #(.IsMd5(IsMd5), .Step(6'(j))) u_cell (
      .clk(clk), .rst(rst),
      .in_valid(v[j]), .in_state(st[j]), .in_iv(iv[j]), .in_blk(bk[j]),
      .out_valid(v[j+1]), .out_state(st[j+1]), .out_iv(iv[j+1]), .out_blk(bk[j+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v[N];
    end
    out_hash.a <= iv[N].a + st[N].a;
    out_hash.b <= iv[N].b + st[N].b;
    out_hash.c <= iv[N].c + st[N].c;
    out_hash.d <= iv[N].d + st[N].d;
  end
endmodule

[rtl/nt_hash_md5_salted_digest.sv]
// Salted NT-hash digest top level: MD4 chain, MD5 chains, output buffer.
// One password request enters per clock while s_tready is high, and one digest
// leaves per clock while m_tready is high. The path is 1 input stage, 48 MD4
// cells + 1 add, 64 MD5 cells + 1 add for the first MD5 block and 64 MD5 cells
// + 1 add for the second block, then the output register. The NT hash
// plus a 48-byte salt is 64 bytes, so the MD5 pad and bit length fill a second
// block that is the same for every request. The cell rows never stall; finished
// digests wait in a 256-entry buffer, and s_tready drops only while 256
// requests are accepted but not yet delivered, which needs a consumer stall.
`include "nt_hash_md5_salted_digest_macros.svh"
module nt_hash_md5_salted_digest (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // key_bytes_0[63:0], key_bytes_1[127:64], key_bytes_2[191:128],
  // key_bytes_3[215:192], key_length[220:216], zero fill to 224
  input  logic [223:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // digest_low[63:0], digest_high[127:64]
  output logic [127:0] m_tdata,
  input  logic         cfg_we,
  input  logic [ntsd_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [63:0]  cfg_data
);
  localparam int FifoDepth = 256;
  localparam int FifoAw    = 8;
  localparam int CntW      = FifoAw + 1;
  localparam logic [FifoAw:0] FifoLimit = FifoDepth[FifoAw:0];

  logic [63:0] salt [ntsd_pkg::SaltRegs];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ntsd_pkg::SaltRegs; i++) salt[i] <= '0;
    end else if (cfg_we && (int'(cfg_index) < ntsd_pkg::SaltRegs)) begin
      salt[cfg_index] <= cfg_data;
    end
  end

  // credit count: requests in flight plus buffered results, never above what
  // the buffer and output register can absorb when the consumer stalls
  logic [CntW-1:0] inflight;
  logic            acc, dlv;
  assign acc = s_tvalid && s_tready;
  assign dlv = m_tvalid && m_tready;
  assign s_tready = (inflight < FifoLimit);

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + CntW'(acc) - CntW'(dlv);
    end
  end

  // MD4 block build
  logic              in_v;
  ntsd_pkg::block_t  md4_blk;
  logic [4:0]        len;
  logic [7:0]        kb [27];
  ntsd_pkg::block_t  bnext;

  always_comb begin
    logic [7:0] by [64];
    logic [8:0] lb;
    len = (s_tdata[220:216] > 5'(ntsd_pkg::MaxKeyChars)) ? 5'(ntsd_pkg::MaxKeyChars)
                                                           : s_tdata[220:216];
    for (int i = 0; i < 27; i++) kb[i] = s_tdata[8*i +: 8];
    for (int i = 0; i < 64; i++) by[i] = 8'h00;
    for (int i = 0; i < 27; i++) if (i < int'(len)) by[2*i] = kb[i];
    by[{len, 1'b0}] = 8'h80;
    lb = {len, 4'b0};
    by[56] = lb[7:0];
    by[57] = {7'b0, lb[8]};
    for (int w = 0; w < 16; w++) bnext[w] = {by[4*w+3], by[4*w+2], by[4*w+1], by[4*w]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else begin
      in_v <= acc;
    end
    md4_blk <= bnext;
  end

  localparam ntsd_pkg::hstate_t Iv = '{a: ntsd_pkg::IvA, b: ntsd_pkg::IvB,
                                       c: ntsd_pkg::IvC, d: ntsd_pkg::IvD};

  logic              nt_v;
  ntsd_pkg::hstate_t nt;

  ntsd_chain #(.IsMd5(1'b0)) u_md4 (
    .clk(clk), .rst(rst), .in_valid(in_v), .in_iv(Iv), .in_blk(md4_blk),
    .out_valid(nt_v), .out_hash(nt)
  );

  // MD5 message: NT hash, salt, pad, bit length
  logic [7:0]       msg [128];
  ntsd_pkg::block_t m0, m1;
  always_comb begin
    logic [63:0] bits;
    for (int i = 0; i < 128; i++) msg[i] = 8'h00;
    for (int i = 0; i < 4; i++) begin
      msg[i]      = nt.a[8*i +: 8];
      msg[4 + i]  = nt.b[8*i +: 8];
      msg[8 + i]  = nt.c[8*i +: 8];
      msg[12 + i] = nt.d[8*i +: 8];
    end
    for (int i = 0; i < ntsd_pkg::SaltBytes; i++) msg[16 + i] = salt[i / 8][8*(i % 8) +: 8];
    msg[ntsd_pkg::TotalBytes] = 8'h80;
    bits = 64'(ntsd_pkg::TotalBytes * 8);
    for (int i = 0; i < 8; i++) msg[64*ntsd_pkg::Md5Blocks - 8 + i] = bits[8*i +: 8];
    for (int w = 0; w < 16; w++) begin
      m0[w] = {msg[4*w+3], msg[4*w+2], msg[4*w+1], msg[4*w]};
      m1[w] = {msg[64+4*w+3], msg[64+4*w+2], msg[64+4*w+1], msg[64+4*w]};
    end
  end

  logic              h1_v, h2_v;
  ntsd_pkg::hstate_t h1, h2, dg;
  logic              dg_v;

  ntsd_chain #(.IsMd5(1'b1)) u_md5a (
    .clk(clk), .rst(rst), .in_valid(nt_v), .in_iv(Iv), .in_blk(m0),
    .out_valid(h1_v), .out_hash(h1)
  );

  if (ntsd_pkg::Md5Blocks == 2) begin : g_two
    // second block holds only pad and length, the same for every request
    ntsd_chain #(.IsMd5(1'b1)) u_md5b (
      .clk(clk), .rst(rst), .in_valid(h1_v), .in_iv(h1), .in_blk(m1),
      .out_valid(h2_v), .out_hash(h2)
    );
    assign dg_v = h2_v;
    assign dg   = h2;
  end else begin : g_one
    assign h2_v = 1'b0;
    assign h2   = h1;
    assign dg_v = h1_v | h2_v;
    assign dg   = h2;
  end

  // result buffer feeding the output register
  logic [127:0]      dnew;
  logic [127:0]      fifo_mem [FifoDepth];
  logic [FifoAw-1:0] wr_ptr, rd_ptr;
  logic [FifoAw:0]   fifo_cnt;
  logic              out_load, fifo_pop, fifo_push;

  assign dnew      = {dg.d, dg.c, dg.b, dg.a};
  assign out_load  = !m_tvalid || m_tready;
  assign fifo_pop  = out_load && (fifo_cnt != '0);
  assign fifo_push = dg_v && !(out_load && (fifo_cnt == '0));

  always_ff @(posedge clk) begin
    if (fifo_push) fifo_mem[wr_ptr] <= dnew;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
    end else begin
      if (fifo_push) wr_ptr <= wr_ptr + 1'b1;
      if (fifo_pop) rd_ptr <= rd_ptr + 1'b1;
      fifo_cnt <= fifo_cnt + (FifoAw+1)'(fifo_push) - (FifoAw+1)'(fifo_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= (fifo_cnt != '0) || dg_v;
    end
  end

  // buffered results are older than the one leaving the cell rows
  always_ff @(posedge clk) begin
    if (out_load) m_tdata <= (fifo_cnt != '0) ? fifo_mem[rd_ptr] : dnew;
  end

  `NTS_ASSERT_IMPL(a_no_overflow, clk, rst, fifo_push, fifo_cnt < FifoLimit)
  `NTS_ASSERT_IMPL(a_credit_bound, clk, rst, 1'b1, inflight <= FifoLimit)
  `NTS_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule
